FILE: hw/rtl/oaht_pkg.sv
package oaht_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int LOGIN_BYTES = 8;
	localparam int LOGIN_W = 64;
	localparam int DHI_W = 64;
	localparam int DMID_W = 64;
	localparam int DLO_W = 32;
	localparam int SLOT_DATA_W = LOGIN_W + DHI_W + DMID_W + DLO_W;
	localparam logic [31:0] MULT_A = 32'd2654431523;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] MARK_FREE = 2'd0;
	localparam logic [1:0] MARK_USED = 2'd1;
	localparam logic [1:0] MARK_GONE = 2'd2;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       hash;
		logic       mul;
		logic       home;
		logic       probe_init;
		logic       probe_next;
		logic       rd;
		logic       wr_mark;
		logic [1:0] mark;
		logic       wr_data;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       respond;
		logic [1:0] status;
		logic       show_digest;
	} oaht_cmd_t;

	typedef struct packed {
		logic       clear_last;
		logic       hash_last;
		logic       probe_last;
		logic       nearly_full;
		logic [1:0] op;
		logic [1:0] mark;
		logic       match;
	} oaht_sts_t;

endpackage

FILE: hw/rtl/oaht_ctrl.sv
module oaht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  oaht_pkg::oaht_sts_t sts,
	output oaht_pkg::oaht_cmd_t cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_MUL = 3'd3;
	localparam logic [2:0] S_HOME = 3'd4;
	localparam logic [2:0] S_RD = 3'd5;
	localparam logic [2:0] S_EV = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				if (sts.hash_last) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_HOME;
			end
			S_HOME: begin
				cmd.home = 1'b1;
				cmd.probe_init = 1'b1;
				state_d = S_RD;
				if (!(sts.op inside {oaht_pkg::OP_INSERT, oaht_pkg::OP_LOOKUP,
					oaht_pkg::OP_DELETE})) begin
					cmd.respond = 1'b1;
					cmd.status = oaht_pkg::ST_NOT_FOUND;
					state_d = S_IDLE;
				end else if (sts.op == oaht_pkg::OP_INSERT && sts.nearly_full) begin
					cmd.respond = 1'b1;
					cmd.status = oaht_pkg::ST_FULL;
					state_d = S_IDLE;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				state_d = S_RD;
				cmd.probe_next = 1'b1;
				case (sts.op)
					oaht_pkg::OP_INSERT: begin
						if (sts.mark inside {oaht_pkg::MARK_FREE, oaht_pkg::MARK_GONE}) begin
							cmd.wr_mark = 1'b1;
							cmd.mark = oaht_pkg::MARK_USED;
							cmd.wr_data = 1'b1;
							cmd.cnt_inc = 1'b1;
							cmd.respond = 1'b1;
							cmd.status = oaht_pkg::ST_DONE;
							state_d = S_IDLE;
						end else if (sts.probe_last) begin
							cmd.respond = 1'b1;
							cmd.status = oaht_pkg::ST_FULL;
							state_d = S_IDLE;
						end
					end
					oaht_pkg::OP_LOOKUP: begin
						if (sts.mark == oaht_pkg::MARK_USED && sts.match) begin
							cmd.respond = 1'b1;
							cmd.status = oaht_pkg::ST_DONE;
							cmd.show_digest = 1'b1;
							state_d = S_IDLE;
						end else if (sts.mark == oaht_pkg::MARK_FREE || sts.probe_last) begin
							cmd.respond = 1'b1;
							cmd.status = oaht_pkg::ST_NOT_FOUND;
							state_d = S_IDLE;
						end
					end
					default: begin
						// Delete walks the whole probe path, free slots included.
						if (sts.mark == oaht_pkg::MARK_USED && sts.match) begin
							cmd.wr_mark = 1'b1;
							cmd.mark = oaht_pkg::MARK_GONE;
							cmd.cnt_dec = 1'b1;
							cmd.respond = 1'b1;
							cmd.status = oaht_pkg::ST_DONE;
							state_d = S_IDLE;
						end else if (sts.probe_last) begin
							cmd.respond = 1'b1;
							cmd.status = oaht_pkg::ST_NOT_FOUND;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/oaht_dp.sv
module oaht_dp #(
	parameter int CAPACITY = oaht_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  oaht_pkg::oaht_cmd_t               cmd,
	output oaht_pkg::oaht_sts_t               sts,
	input  logic [1:0]                        operation,
	input  logic [oaht_pkg::LOGIN_W-1:0]      login_chars,
	input  logic [oaht_pkg::DHI_W-1:0]        digest_high,
	input  logic [oaht_pkg::DMID_W-1:0]       digest_mid,
	input  logic [oaht_pkg::DLO_W-1:0]        digest_low,
	output logic                              strobe,
	output logic [1:0]                        result_status,
	output logic [oaht_pkg::DHI_W-1:0]        out_digest_high,
	output logic [oaht_pkg::DMID_W-1:0]       out_digest_mid,
	output logic [oaht_pkg::DLO_W-1:0]        out_digest_low
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DW = oaht_pkg::SLOT_DATA_W;
	localparam int LW = oaht_pkg::LOGIN_W;

	logic [1:0]       mark_mem [CAPACITY];
	logic [DW-1:0]    data_mem [CAPACITY];

	logic [1:0]       op_q;
	logic [LW-1:0]    login_q;
	logic [oaht_pkg::DHI_W-1:0]  dhi_q;
	logic [oaht_pkg::DMID_W-1:0] dmid_q;
	logic [oaht_pkg::DLO_W-1:0]  dlo_q;
	logic [LW-1:0]    hsh_q;
	logic [2:0]       hcnt_q;
	logic [31:0]      h_q;
	logic [31:0]      frac_q;
	logic [IDX_W-1:0] home_q;
	logic [IDX_W-1:0] sq_q;
	logic [IDX_W-1:0] odd_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       mark_rd_q;
	logic [DW-1:0]    data_rd_q;
	logic             strobe_q;
	logic [1:0]       status_q;
	logic [DW-LW-1:0] dig_q;

	logic [LW-1:0]    canon;
	logic [31+CNT_W:0] home_prod;
	logic [IDX_W:0]   slot_sum;
	logic [IDX_W-1:0] slot;
	logic [IDX_W:0]   sq_sum;
	logic [IDX_W:0]   odd_sum;
	logic [IDX_W-1:0] wr_addr;

	// Bytes up to the first NUL are kept, limited to the login length.
	always_comb begin
		logic run;
		run = 1'b1;
		canon = '0;
		for (int k = 0; k < 8; k++) begin
			if (k >= oaht_pkg::LOGIN_BYTES || login_chars[8*k +: 8] == 8'd0) begin
				run = 1'b0;
			end
			if (run) begin
				canon[8*k +: 8] = login_chars[8*k +: 8];
			end
		end
	end

	assign home_prod = {{CNT_W{1'b0}}, frac_q} * (CNT_W + 32)'(CAPACITY);
	assign slot_sum = {1'b0, home_q} + {1'b0, sq_q};
	assign slot = (slot_sum >= (IDX_W + 1)'(CAPACITY)) ?
		IDX_W'(slot_sum - (IDX_W + 1)'(CAPACITY)) : slot_sum[IDX_W-1:0];
	assign sq_sum = {1'b0, sq_q} + {1'b0, odd_q};
	assign odd_sum = {1'b0, odd_q} + (IDX_W + 1)'(2);
	assign wr_addr = cmd.clear ? clr_q : slot_q;

	always_ff @(posedge clk) begin
		if (cmd.clear || cmd.wr_mark) begin
			mark_mem[wr_addr] <= cmd.clear ? oaht_pkg::MARK_FREE : cmd.mark;
		end
		if (cmd.wr_data) begin
			data_mem[slot_q] <= {login_q, dhi_q, dmid_q, dlo_q};
		end
		mark_rd_q <= mark_mem[slot];
		data_rd_q <= data_mem[slot];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			login_q <= canon;
			hsh_q <= canon;
			dhi_q <= digest_high;
			dmid_q <= digest_mid;
			dlo_q <= digest_low;
			h_q <= '0;
		end
		if (cmd.hash) begin
			hsh_q <= {8'd0, hsh_q[LW-1:8]};
			if (hsh_q[7:0] != 8'd0) begin
				h_q <= (h_q << 5) - h_q + {24'd0, hsh_q[7:0]};
			end
		end
		if (cmd.mul) begin
			frac_q <= h_q * oaht_pkg::MULT_A;
		end
		if (cmd.home) begin
			home_q <= home_prod[32 +: IDX_W];
		end
		// Squares advance by successive odd numbers, all kept below the capacity.
		if (cmd.probe_init) begin
			sq_q <= '0;
			odd_q <= IDX_W'(1);
			i_q <= '0;
		end else if (cmd.probe_next) begin
			sq_q <= (sq_sum >= (IDX_W + 1)'(CAPACITY)) ?
				IDX_W'(sq_sum - (IDX_W + 1)'(CAPACITY)) : sq_sum[IDX_W-1:0];
			odd_q <= (odd_sum >= (IDX_W + 1)'(CAPACITY)) ?
				IDX_W'(odd_sum - (IDX_W + 1)'(CAPACITY)) : odd_sum[IDX_W-1:0];
			i_q <= i_q + IDX_W'(1);
		end
		if (cmd.rd) begin
			slot_q <= slot;
		end
		if (cmd.respond) begin
			status_q <= cmd.status;
			dig_q <= cmd.show_digest ? data_rd_q[DW-LW-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			clr_q <= '0;
			count_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				hcnt_q <= '0;
			end else if (cmd.hash) begin
				hcnt_q <= hcnt_q + 3'd1;
			end
			if (cmd.clear) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec && count_q != '0) begin
				count_q <= count_q - CNT_W'(1);
			end
			strobe_q <= cmd.respond;
		end
	end

	always_comb begin
		sts.clear_last = (clr_q == IDX_W'(CAPACITY - 1));
		sts.hash_last = (hcnt_q == 3'd7);
		sts.probe_last = (i_q == IDX_W'(CAPACITY - 1));
		sts.nearly_full = ({count_q, 2'b00} >= (CNT_W + 2)'(CAPACITY * 3));
		sts.op = op_q;
		sts.mark = mark_rd_q;
		sts.match = (data_rd_q[DW-1 -: LW] == login_q);
	end

	assign strobe = strobe_q;
	assign result_status = status_q;
	assign out_digest_high = dig_q[DW-LW-1 -: oaht_pkg::DHI_W];
	assign out_digest_mid = dig_q[oaht_pkg::DLO_W +: oaht_pkg::DMID_W];
	assign out_digest_low = dig_q[oaht_pkg::DLO_W-1:0];

endmodule

FILE: hw/rtl/open_address_hash_table.sv
// A rejected insert or an unused operation is answered without probing; otherwise a request
// makes P probes before strobe, where P is at most CAPACITY.
// Each probe is one registered read of the slot memories followed by one evaluation state.
// One request at a time; busy falls as the result is shown, so the next start can follow.
// After reset busy stays high while all slot marks are cleared to free.
// Results are shown for one cycle on strobe and cannot be held off by the receiver.
module open_address_hash_table #(
	parameter int CAPACITY = oaht_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   operation,
	input  logic [oaht_pkg::LOGIN_W-1:0] login_chars,
	input  logic [oaht_pkg::DHI_W-1:0]   digest_high,
	input  logic [oaht_pkg::DMID_W-1:0]  digest_mid,
	input  logic [oaht_pkg::DLO_W-1:0]   digest_low,
	output logic                         strobe,
	output logic [1:0]                   result_status,
	output logic [oaht_pkg::DHI_W-1:0]   out_digest_high,
	output logic [oaht_pkg::DMID_W-1:0]  out_digest_mid,
	output logic [oaht_pkg::DLO_W-1:0]   out_digest_low
);

	oaht_pkg::oaht_cmd_t cmd;
	oaht_pkg::oaht_sts_t sts;

	oaht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	oaht_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.login_chars     (login_chars),
		.digest_high     (digest_high),
		.digest_mid      (digest_mid),
		.digest_low      (digest_low),
		.strobe          (strobe),
		.result_status   (result_status),
		.out_digest_high (out_digest_high),
		.out_digest_mid  (out_digest_mid),
		.out_digest_low  (out_digest_low)
	);

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("result shown while a request is in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result_status == oaht_pkg::ST_DONE ||
			result_status == oaht_pkg::ST_NOT_FOUND ||
			result_status == oaht_pkg::ST_FULL)) else $error("unknown result status");

	a_digest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result_status != oaht_pkg::ST_DONE) |->
			(out_digest_high == '0 && out_digest_mid == '0 && out_digest_low == '0))
		else $error("digest not cleared on a miss");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !strobe)) else $error("accepted request did not start");

endmodule
